>>> rtl/fpsa_pkg.sv
// fpsa_pkg: shared widths, constants and transaction types of the
// four-point stencil average block; no dependencies
`timescale 1ns / 1ps

package fpsa_pkg;

   // field widths fixed by the interface
   localparam int SAMPLE_W = 16;
   localparam int CSR_W    = 9;
   localparam int IDX_W    = 8;

   // minimum matrix size and size reset value
   localparam int             MIN_SIZE   = 3;
   localparam logic [CSR_W-1:0] SIZE_RESET = 9'd16;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // input transaction: one matrix element in raster order
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       frame_start;
   } req_type;

   // result transaction: one interior cell
   typedef struct packed {
      logic [IDX_W-1:0]           out_row;
      logic [IDX_W-1:0]           out_col;
      logic signed [SAMPLE_W-1:0] average;
      logic                       last_interior;
   } rsp_type;

endpackage

>>> rtl/four_point_stencil_average.sv
// four_point_stencil_average: one-sweep 4-point Jacobi stencil over a raster stream
// depends on fpsa_pkg (types, widths, size limits)
`timescale 1ns / 1ps

// Usage
// - req channel (req_valid/req_ready/req_data) takes one matrix element per
//   transaction in raster order; frame_start marks element (0,0). Counts also
//   wrap by themselves after the last element, so frames may run back to back.
// - csr channel writes the matrix size (clamped to 3..MAX_SIZE); csr_ready is
//   always high. Write it only while the block is idle.
// - rsp channel returns one transaction per interior cell (r,c), produced when
//   element (r+1,c+1) arrives; border cells give no transaction.
// - Throughput: one element per cycle while rsp does not stall, set by the two
//   line memories, each read once and written once per element, with registered reads.
// - Result path: a producing element passes the memory read stage, then the
//   output register, before its result is on rsp.
// - When rsp stalls, elements keep flowing until a producing one reaches the
//   read stage; req_ready then drops until the output register is freed.
// - Reset (synchronous, active high) clears counts, window and size (16).
//   Line memories are not cleared; entries are written before they are used.
module four_point_stencil_average #(
   parameter int MAX_SIZE = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  fpsa_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output fpsa_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [fpsa_pkg::CSR_W-1:0]         csr_data
);

   localparam int CNT_W = $clog2(MAX_SIZE);
   localparam int NW    = $clog2(MAX_SIZE + 1);
   localparam int CW    = (NW > fpsa_pkg::CSR_W) ? NW : fpsa_pkg::CSR_W;
   localparam int SUM_W = fpsa_pkg::SAMPLE_W + 2;

   // size register
   logic [fpsa_pkg::CSR_W-1:0] size_ff, size_in;
   logic [CW-1:0]              size_ext, size_clamp;
   logic [NW-1:0]              n_use;

   // position counts
   logic [CNT_W-1:0] row_cnt_ff, row_cnt_in, col_cnt_ff, col_cnt_in;
   logic [CNT_W-1:0] r_cur, c_cur, two_addr;
   logic [NW-1:0]    r_n, c_n, r_next, c_next;
   logic             produce, last_cell, req_fire;

   // line memories and their registered read data
   fpsa_pkg::sample_type above_mem [MAX_SIZE];
   fpsa_pkg::sample_type two_mem   [MAX_SIZE];
   fpsa_pkg::sample_type above_rd_ff, two_rd_ff;

   // read stage
   logic                        s1_valid_ff, s1_valid_in;
   logic                        s1_produce_ff, s1_last_ff, s1_two_wr_ff;
   logic [fpsa_pkg::IDX_W-1:0]  s1_row_ff, s1_col_ff;
   logic [CNT_W-1:0]            s1_two_addr_ff;
   fpsa_pkg::sample_type        s1_sample_ff;
   logic                        s1_go, s1_fire;

   // window registers
   fpsa_pkg::sample_type prev_ff, above_mid_ff, above_left_ff;

   // stencil arithmetic
   logic signed [SUM_W-1:0]    sum, sum_biased;
   fpsa_pkg::sample_type       avg;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   fpsa_pkg::rsp_type   rsp_data_ff;

   // config write
   assign csr_ready = 1'b1;
   always_comb begin
      size_in = size_ff;
      if (csr_valid) begin
         size_in = csr_data;
      end
   end

   // clamp size to the supported range
   always_comb begin
      size_ext = CW'(size_ff);
      if (size_ext < CW'(fpsa_pkg::MIN_SIZE)) begin
         size_clamp = CW'(fpsa_pkg::MIN_SIZE);
      end else if (size_ext > CW'(MAX_SIZE)) begin
         size_clamp = CW'(MAX_SIZE);
      end else begin
         size_clamp = size_ext;
      end
      n_use = size_clamp[NW-1:0];
   end

   // handshake
   assign s1_go     = !s1_produce_ff || !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && s1_go;
   assign req_ready = !s1_valid_ff || s1_go;
   assign req_fire  = req_valid && req_ready;

   // position of the arriving element and the cell it completes
   always_comb begin
      r_cur     = req_data.frame_start ? '0 : row_cnt_ff;
      c_cur     = req_data.frame_start ? '0 : col_cnt_ff;
      r_n       = NW'(r_cur);
      c_n       = NW'(c_cur);
      two_addr  = (c_cur == '0) ? '0 : c_cur - CNT_W'(1);
      produce   = (r_n >= NW'(2)) && (r_n < n_use) && (c_n >= NW'(2)) && (c_n < n_use);
      last_cell = (r_n == n_use - NW'(1)) && (c_n == n_use - NW'(1));
   end

   // count advance with wrap at the matrix size
   always_comb begin
      row_cnt_in = row_cnt_ff;
      col_cnt_in = col_cnt_ff;
      c_next     = c_n + NW'(1);
      r_next     = r_n + NW'(1);
      if (req_fire) begin
         if (c_next >= n_use) begin
            col_cnt_in = '0;
            if (r_next >= n_use) begin
               row_cnt_in = '0;
            end else begin
               row_cnt_in = r_next[CNT_W-1:0];
            end
         end else begin
            col_cnt_in = c_next[CNT_W-1:0];
            row_cnt_in = r_cur;
         end
      end
   end

   // line above: read old entry, write new sample at the same column
   always_ff @(posedge clock) begin
      if (req_fire) begin
         above_rd_ff      <= above_mem[c_cur];
         above_mem[c_cur] <= req_data.sample;
      end
   end

   // line two above: read on accept, written back from the window when the element leaves the read stage
   always_ff @(posedge clock) begin
      if (req_fire) begin
         two_rd_ff <= two_mem[two_addr];
      end
      if (s1_fire && s1_two_wr_ff) begin
         two_mem[s1_two_addr_ff] <= above_mid_ff;
      end
   end

   // read stage payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_produce_ff  <= produce;
         s1_last_ff     <= last_cell;
         s1_row_ff      <= fpsa_pkg::IDX_W'(r_n - NW'(1));
         s1_col_ff      <= fpsa_pkg::IDX_W'(c_n - NW'(1));
         s1_two_wr_ff   <= (c_cur != '0);
         s1_two_addr_ff <= two_addr;
         s1_sample_ff   <= req_data.sample;
      end
   end

   // four-neighbour sum, divided by 4 toward zero
   always_comb begin
      sum = SUM_W'(above_left_ff) + SUM_W'(above_rd_ff) + SUM_W'(two_rd_ff) + SUM_W'(prev_ff);
      sum_biased = sum[SUM_W-1] ? sum + SUM_W'(3) : sum;
      avg = sum_biased[SUM_W-1:2];
   end

   assign rsp_valid_in = (s1_fire && s1_produce_ff) ? 1'b1
                       : (rsp_ready ? 1'b0 : rsp_valid_ff);
   assign s1_valid_in  = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);

   // output payload
   always_ff @(posedge clock) begin
      if (s1_fire && s1_produce_ff) begin
         rsp_data_ff.out_row       <= s1_row_ff;
         rsp_data_ff.out_col       <= s1_col_ff;
         rsp_data_ff.average       <= avg;
         rsp_data_ff.last_interior <= s1_last_ff;
      end
   end

   // control state and window
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff       <= fpsa_pkg::SIZE_RESET;
         row_cnt_ff    <= '0;
         col_cnt_ff    <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         prev_ff       <= '0;
         above_mid_ff  <= '0;
         above_left_ff <= '0;
      end else begin
         size_ff      <= size_in;
         row_cnt_ff   <= row_cnt_in;
         col_cnt_ff   <= col_cnt_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) begin
            above_left_ff <= above_mid_ff;
            above_mid_ff  <= above_rd_ff;
            prev_ff       <= s1_sample_ff;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a producing item leaving the read stage lands in the output register
   assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_produce_ff |=> rsp_valid && (rsp_data.average == $past(avg)))
      else $error("result lost between read stage and output register");

   // the final interior cell lies on the diagonal
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_interior |-> rsp_data.out_row == rsp_data.out_col)
      else $error("last interior cell off the diagonal");

   // a stalled output holds a waiting producing item in the read stage
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_produce_ff && rsp_valid && !rsp_ready
      |=> s1_valid_ff && $stable(s1_row_ff) && $stable(s1_col_ff))
      else $error("read stage moved while output stalled");

endmodule
